// ===== hdl/scc_pkg.sv =====
// Shared types, constants and sequencer states for the component finder.
package scc_pkg;

    localparam int NODE_W   = 6;
    localparam int NODE_NUM = 1 << NODE_W;
    localparam int EDGES    = 1024;
    localparam int EDGE_AW  = $clog2(EDGES);
    localparam int FILL_W   = EDGE_AW + 1;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Register byte offsets.
    localparam logic [APB_AW-1:0] REG_NODE_COUNT = 3'd0;
    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 6'd63;

    // Result kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_MEMBER = 1'b1;

    typedef struct packed {
        logic [NODE_W-1:0] tgt;
        logic [NODE_W-1:0] src;
    } edge_t;

    typedef struct packed {
        logic [FILL_W-1:0] cursor;
        logic [NODE_W-1:0] node;
    } frame_t;

    typedef struct packed {
        logic [NODE_W-1:0] low;
        logic [NODE_W-1:0] disc;
    } nrec_t;

    typedef struct packed {
        logic              kind;
        logic [NODE_W-1:0] value;
        logic              cend;
        logic              ovf;
        logic              last;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROOT,
        ST_EDGE_RD,
        ST_EDGE_CHK,
        ST_PUSH,
        ST_BACK,
        ST_POP,
        ST_POP_RD,
        ST_POP_CHK,
        ST_RET,
        ST_RET2,
        ST_RET3,
        ST_OUT_HDR,
        ST_OUT_V,
        ST_OUT_VC,
        ST_OUT_W,
        ST_OUT_WC,
        ST_OUT_FLUSH,
        ST_CLEAR
    } state_t;

endpackage

// ===== hdl/scc_ram.sv =====
// Generic single write port RAM with a registered read port.
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/scc_cfg.sv =====
// APB register block holding the node count.
module scc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scc_pkg::APB_AW-1:0]  paddr,
    input  logic [scc_pkg::APB_DW-1:0]  pwdata,
    output logic [scc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [scc_pkg::NODE_W-1:0]  node_count
);
    import scc_pkg::*;

    logic [NODE_W-1:0] count_reg;
    logic [NODE_W-1:0] count_next;
    logic              hit;

    // Registers are word aligned; the low address bits are ignored.
    assign hit    = (paddr[APB_AW-1:2] == REG_NODE_COUNT[APB_AW-1:2]);
    assign pready = 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (psel && penable && pwrite && hit)
        begin
            count_next = pwdata[NODE_W-1:0];
        end
        prdata = hit ? {{(APB_DW-NODE_W){1'b0}}, count_reg} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= NODE_COUNT_RST;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign node_count = count_reg;

endmodule

// ===== hdl/scc_core.sv =====
// Edge loader, depth-first sequencer and sorted component reporter.
module scc_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [scc_pkg::NODE_W-1:0]  node_count,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  scc_pkg::edge_t              in_edge,
    input  logic                        in_has_edge,
    input  logic                        in_last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output scc_pkg::result_t            out_res
);
    import scc_pkg::*;

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                drop_reg, drop_next;
    logic [NODE_NUM-1:0] visited_reg, visited_next;
    logic [NODE_NUM-1:0] onstk_reg, onstk_next;
    logic [NODE_NUM-1:0] done_reg, done_next;
    logic [NODE_W:0]     r_reg, r_next;
    logic [NODE_W-1:0]   tick_reg, tick_next;
    logic [NODE_W-1:0]   sp_reg, sp_next;
    logic [NODE_W-1:0]   fd_reg, fd_next;
    logic [NODE_W-1:0]   cu_reg, cu_next;
    logic [FILL_W-1:0]   ce_reg, ce_next;
    logic [NODE_W-1:0]   cdisc_reg, cdisc_next;
    logic [NODE_W-1:0]   clow_reg, clow_next;
    logic [NODE_W-1:0]   v_reg, v_next;
    logic [NODE_W-1:0]   child_low_reg, child_low_next;
    logic [NODE_W-1:0]   ncomp_reg, ncomp_next;
    logic [NODE_W:0]     ov_reg, ov_next;
    logic [NODE_W:0]     ow_reg, ow_next;
    logic [NODE_W-1:0]   oc_reg, oc_next;
    logic [NODE_W-1:0]   pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [NODE_W-1:0]   emit_reg, emit_next;
    logic                ovalid_reg, ovalid_next;
    result_t             ores_reg, ores_next;

    logic                e_we;
    logic [EDGE_AW-1:0]  e_waddr;
    edge_t               e_rd;
    logic                n_we;
    logic [NODE_W-1:0]   n_waddr, n_raddr;
    nrec_t               n_wdata, n_rd;
    logic                s_we;
    logic [NODE_W-1:0]   s_waddr, s_wdata, s_rd;
    logic                f_we;
    frame_t              f_wdata, f_rd;
    logic                c_we;
    logic [NODE_W-1:0]   c_waddr, c_raddr, c_rd;
    logic                out_free;
    logic [NODE_W:0]     n_ext;
    logic [NODE_W-1:0]   tick_inc;
    logic                last_member;

    scc_ram #(.WIDTH($bits(edge_t)), .DEPTH(EDGES)) u_edge_ram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(in_edge),
        .raddr(ce_reg[EDGE_AW-1:0]), .rdata(e_rd)
    );

    scc_ram #(.WIDTH($bits(nrec_t)), .DEPTH(NODE_NUM)) u_node_ram (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rd)
    );

    scc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_NUM)) u_stack_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(sp_reg - 1'b1), .rdata(s_rd)
    );

    scc_ram #(.WIDTH($bits(frame_t)), .DEPTH(NODE_NUM)) u_frame_ram (
        .clk(clk), .we(f_we), .waddr(fd_reg - 1'b1), .wdata(f_wdata),
        .raddr(fd_reg - 1'b1), .rdata(f_rd)
    );

    scc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_NUM)) u_comp_ram (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(ncomp_reg),
        .raddr(c_raddr), .rdata(c_rd)
    );

    assign n_ext       = {1'b0, node_count};
    assign tick_inc    = tick_reg + 1'b1;
    assign out_free    = !ovalid_reg || out_ready;
    assign last_member = ({1'b0, emit_reg} + 1'b1) == n_ext;
    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = ovalid_reg;
    assign out_res     = ores_reg;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        drop_next       = drop_reg;
        visited_next    = visited_reg;
        onstk_next      = onstk_reg;
        done_next       = done_reg;
        r_next          = r_reg;
        tick_next       = tick_reg;
        sp_next         = sp_reg;
        fd_next         = fd_reg;
        cu_next         = cu_reg;
        ce_next         = ce_reg;
        cdisc_next      = cdisc_reg;
        clow_next       = clow_reg;
        v_next          = v_reg;
        child_low_next  = child_low_reg;
        ncomp_next      = ncomp_reg;
        ov_next         = ov_reg;
        ow_next         = ow_reg;
        oc_next         = oc_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        emit_next       = emit_reg;
        ovalid_next     = ovalid_reg && !out_ready;
        ores_next       = ores_reg;

        e_we    = 1'b0;
        e_waddr = fill_reg[EDGE_AW-1:0];
        n_we    = 1'b0;
        n_waddr = cu_reg;
        n_wdata = '{low: clow_reg, disc: cdisc_reg};
        n_raddr = (state_reg == ST_RET2) ? f_rd.node : e_rd.tgt;
        s_we    = 1'b0;
        s_waddr = sp_reg;
        s_wdata = v_reg;
        f_we    = 1'b0;
        f_wdata = '{cursor: ce_reg + 1'b1, node: cu_reg};
        c_we    = 1'b0;
        c_waddr = s_rd;
        c_raddr = (state_reg == ST_OUT_V || state_reg == ST_OUT_VC) ?
                  ov_reg[NODE_W-1:0] : ow_reg[NODE_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_has_edge)
                    begin
                        if (fill_reg < FILL_W'(EDGES))
                        begin
                            e_we      = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    if (in_last)
                    begin
                        r_next     = (NODE_W+1)'(1);
                        tick_next  = '0;
                        sp_next    = '0;
                        ncomp_next = '0;
                        state_next = ST_ROOT;
                    end
                end
            end

            ST_ROOT:
            begin
                if (r_reg > n_ext)
                begin
                    state_next = ST_OUT_HDR;
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                    if (!visited_reg[r_reg[NODE_W-1:0]])
                    begin
                        tick_next  = tick_inc;
                        n_we       = 1'b1;
                        n_waddr    = r_reg[NODE_W-1:0];
                        n_wdata    = '{low: tick_inc, disc: tick_inc};
                        s_we       = 1'b1;
                        s_wdata    = r_reg[NODE_W-1:0];
                        sp_next    = sp_reg + 1'b1;
                        onstk_next[r_reg[NODE_W-1:0]]   = 1'b1;
                        visited_next[r_reg[NODE_W-1:0]] = 1'b1;
                        cu_next    = r_reg[NODE_W-1:0];
                        cdisc_next = tick_inc;
                        clow_next  = tick_inc;
                        ce_next    = '0;
                        fd_next    = NODE_W'(1);
                        state_next = ST_EDGE_RD;
                    end
                end
            end

            ST_EDGE_RD:
            begin
                state_next = (ce_reg < fill_reg) ? ST_EDGE_CHK : ST_POP;
            end

            ST_EDGE_CHK:
            begin
                ce_next    = ce_reg + 1'b1;
                state_next = ST_EDGE_RD;
                if (e_rd.src == cu_reg && e_rd.tgt != '0 &&
                    {1'b0, e_rd.tgt} <= n_ext)
                begin
                    if (!visited_reg[e_rd.tgt])
                    begin
                        // Save the current frame before descending.
                        n_we       = 1'b1;
                        f_we       = 1'b1;
                        v_next     = e_rd.tgt;
                        state_next = ST_PUSH;
                    end
                    else if (onstk_reg[e_rd.tgt])
                    begin
                        state_next = ST_BACK;
                    end
                end
            end

            ST_PUSH:
            begin
                tick_next  = tick_inc;
                n_we       = 1'b1;
                n_waddr    = v_reg;
                n_wdata    = '{low: tick_inc, disc: tick_inc};
                s_we       = 1'b1;
                sp_next    = sp_reg + 1'b1;
                onstk_next[v_reg]   = 1'b1;
                visited_next[v_reg] = 1'b1;
                cu_next    = v_reg;
                cdisc_next = tick_inc;
                clow_next  = tick_inc;
                ce_next    = '0;
                fd_next    = fd_reg + 1'b1;
                state_next = ST_EDGE_RD;
            end

            ST_BACK:
            begin
                if (n_rd.disc < clow_reg)
                begin
                    clow_next = n_rd.disc;
                end
                state_next = ST_EDGE_RD;
            end

            ST_POP:
            begin
                fd_next        = fd_reg - 1'b1;
                child_low_next = clow_reg;
                state_next     = (clow_reg == cdisc_reg) ? ST_POP_RD : ST_RET;
            end

            ST_POP_RD:
            begin
                state_next = ST_POP_CHK;
            end

            ST_POP_CHK:
            begin
                onstk_next[s_rd] = 1'b0;
                c_we             = 1'b1;
                sp_next          = sp_reg - 1'b1;
                if (s_rd != cu_reg && sp_reg != NODE_W'(1))
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    ncomp_next = ncomp_reg + 1'b1;
                    state_next = ST_RET;
                end
            end

            ST_RET:
            begin
                state_next = (fd_reg == '0) ? ST_ROOT : ST_RET2;
            end

            ST_RET2:
            begin
                cu_next    = f_rd.node;
                ce_next    = f_rd.cursor;
                state_next = ST_RET3;
            end

            ST_RET3:
            begin
                cdisc_next = n_rd.disc;
                clow_next  = (child_low_reg < n_rd.low) ? child_low_reg : n_rd.low;
                state_next = ST_EDGE_RD;
            end

            ST_OUT_HDR:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ores_next   = '{kind: KIND_HEADER, value: ncomp_reg, cend: 1'b0,
                                    ovf: drop_reg, last: (node_count == '0)};
                    ov_next     = (NODE_W+1)'(1);
                    emit_next   = '0;
                    state_next  = (node_count == '0) ? ST_CLEAR : ST_OUT_V;
                end
            end

            ST_OUT_V:
            begin
                state_next = (ov_reg > n_ext) ? ST_CLEAR : ST_OUT_VC;
            end

            ST_OUT_VC:
            begin
                if (done_reg[c_rd])
                begin
                    ov_next    = ov_reg + 1'b1;
                    state_next = ST_OUT_V;
                end
                else
                begin
                    done_next[c_rd] = 1'b1;
                    oc_next         = c_rd;
                    ow_next         = ov_reg;
                    pend_valid_next = 1'b0;
                    state_next      = ST_OUT_W;
                end
            end

            ST_OUT_W:
            begin
                state_next = (ow_reg > n_ext) ? ST_OUT_FLUSH : ST_OUT_WC;
            end

            ST_OUT_WC:
            begin
                // A member is held back until the next one is found, so that
                // the final member of the component can carry its end mark.
                if (c_rd != oc_reg)
                begin
                    ow_next    = ow_reg + 1'b1;
                    state_next = ST_OUT_W;
                end
                else if (!pend_valid_reg)
                begin
                    pend_next       = ow_reg[NODE_W-1:0];
                    pend_valid_next = 1'b1;
                    ow_next         = ow_reg + 1'b1;
                    state_next      = ST_OUT_W;
                end
                else if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ores_next   = '{kind: KIND_MEMBER, value: pend_reg, cend: 1'b0,
                                    ovf: 1'b0, last: last_member};
                    emit_next   = emit_reg + 1'b1;
                    pend_next   = ow_reg[NODE_W-1:0];
                    ow_next     = ow_reg + 1'b1;
                    state_next  = ST_OUT_W;
                end
            end

            ST_OUT_FLUSH:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ores_next   = '{kind: KIND_MEMBER, value: pend_reg, cend: 1'b1,
                                    ovf: 1'b0, last: last_member};
                    emit_next   = emit_reg + 1'b1;
                    ov_next     = ov_reg + 1'b1;
                    state_next  = ST_OUT_V;
                end
            end

            ST_CLEAR:
            begin
                fill_next    = '0;
                drop_next    = 1'b0;
                visited_next = '0;
                onstk_next   = '0;
                done_next    = '0;
                state_next   = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            drop_reg    <= 1'b0;
            visited_reg <= '0;
            onstk_reg   <= '0;
            done_reg    <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            drop_reg    <= drop_next;
            visited_reg <= visited_next;
            onstk_reg   <= onstk_next;
            done_reg    <= done_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg          <= r_next;
        tick_reg       <= tick_next;
        sp_reg         <= sp_next;
        fd_reg         <= fd_next;
        cu_reg         <= cu_next;
        ce_reg         <= ce_next;
        cdisc_reg      <= cdisc_next;
        clow_reg       <= clow_next;
        v_reg          <= v_next;
        child_low_reg  <= child_low_next;
        ncomp_reg      <= ncomp_next;
        ov_reg         <= ov_next;
        ow_reg         <= ow_next;
        oc_reg         <= oc_next;
        pend_reg       <= pend_next;
        pend_valid_reg <= pend_valid_next;
        emit_reg       <= emit_next;
        ores_reg       <= ores_next;
    end

endmodule

// ===== hdl/strongly_connected_components.sv =====
// Top level of the strongly connected components finder.
// Edge transactions are accepted while the block is idle; it stays ready after each one but the last.
// The last transaction starts a depth-first walk on one shared edge memory port: each edge
// examined passes a read state and a check state, each node scanning the edge list once.
// Reporting then scans the remaining nodes for each component through the component memory read port.
// rst_n clears the control state asynchronously; node_count resets to 63.
module strongly_connected_components (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [scc_pkg::APB_AW-1:0]  paddr,
    input  logic [scc_pkg::APB_DW-1:0]  pwdata,
    output logic [scc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,  // from_node[5:0], to_node[11:6], zero pad
    input  logic                        s_tlast,  // last_edge
    input  logic                        s_tuser,  // has_edge
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,  // value[5:0], component_end[6], overflow[7]
    output logic                        m_tlast,  // last
    output logic                        m_tuser   // kind
);
    import scc_pkg::*;

    logic [NODE_W-1:0] node_count;
    edge_t             in_edge;
    result_t           res;

    assign in_edge = '{tgt: s_tdata[2*NODE_W-1:NODE_W], src: s_tdata[NODE_W-1:0]};

    scc_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .node_count(node_count)
    );

    scc_core u_core (
        .clk(clk), .rst_n(rst_n), .node_count(node_count),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_edge(in_edge),
        .in_has_edge(s_tuser), .in_last(s_tlast),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {res.ovf, res.cend, res.value};
    assign m_tlast = res.last;
    assign m_tuser = res.kind;

endmodule

// ===== bench/strongly_connected_components_tb.sv =====
// Self-checking testbench for the strongly connected components finder.
`timescale 1ns / 1ps

module strongly_connected_components_tb;
    import scc_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES = 3000;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;   // from_node[5:0], to_node[11:6], zero pad
    logic                s_tlast;   // last_edge
    logic                s_tuser;   // has_edge
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;   // value[5:0], component_end[6], overflow[7]
    logic                m_tlast;   // last
    logic                m_tuser;   // kind

    // Predictor state: the loaded edge list, the sticky drop flag and the node count.
    logic [NODE_W-1:0]   edge_src_q[$];
    logic [NODE_W-1:0]   edge_dst_q[$];
    bit                  edges_dropped;
    int                  node_count_cfg;
    result_t             expected_results[$];

    int                  mismatches;
    int                  results_seen;
    int                  graphs_sent;
    int                  items_sent;
    int                  cycle_count;
    bit                  quiet;
    int                  hold_seq;
    int                  hold_seen;
    int                  hold_left;
    int                  stall_left;

    strongly_connected_components uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 99) < 60)
            return 0;
        if ($urandom_range(0, 9) < 9)
            return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // Tarjan's algorithm with an explicit frame stack, then the sorted report.
    task automatic predict_components();
        int n, tick, ncomp, sp, fd, u, e, v, y, p, c, lastw, nfill;
        int disc[64], low[64], comp[64], stk[64], fnode[64], fcur[64];
        bit onst[64], done[64];
        result_t rows[$];
        result_t row;
        n = node_count_cfg;
        nfill = edge_src_q.size();
        for (int i = 0; i < 64; i++)
        begin
            disc[i] = 0; low[i] = 0; comp[i] = 0; stk[i] = 0;
            fnode[i] = 0; fcur[i] = 0; onst[i] = 0; done[i] = 0;
        end
        tick = 0; ncomp = 0; sp = 0;
        for (int root = 1; root <= n; root++)
        begin
            if (disc[root] != 0)
                continue;
            tick++;
            disc[root] = tick; low[root] = tick;
            stk[sp & 63] = root; sp++;
            onst[root] = 1;
            fnode[0] = root; fcur[0] = 0; fd = 1;
            while (fd > 0)
            begin
                u = fnode[(fd - 1) & 63];
                e = fcur[(fd - 1) & 63];
                while (e < nfill && edge_src_q[e] != u)
                    e++;
                if (e < nfill)
                begin
                    fcur[(fd - 1) & 63] = e + 1;
                    v = edge_dst_q[e];
                    if (v == 0 || v > n)
                        continue;
                    if (disc[v] == 0)
                    begin
                        tick++;
                        disc[v] = tick; low[v] = tick;
                        stk[sp & 63] = v; sp++;
                        onst[v] = 1;
                        fnode[fd & 63] = v; fcur[fd & 63] = 0; fd++;
                    end
                    else if (onst[v] && disc[v] < low[u])
                        low[u] = disc[v];
                end
                else
                begin
                    fd--;
                    if (low[u] == disc[u])
                    begin
                        do
                        begin
                            sp--;
                            y = stk[sp & 63];
                            onst[y] = 0;
                            comp[y] = ncomp;
                        end while (y != u && sp > 0);
                        ncomp++;
                    end
                    if (fd > 0)
                    begin
                        p = fnode[(fd - 1) & 63];
                        if (low[u] < low[p])
                            low[p] = low[u];
                    end
                end
            end
        end
        row = '{kind: KIND_HEADER, value: ncomp[NODE_W-1:0], cend: 1'b0,
                ovf: edges_dropped, last: 1'b0};
        rows = {rows, row};
        for (int a = 1; a <= n; a++)
        begin
            c = comp[a] & 63;
            if (done[c])
                continue;
            done[c] = 1;
            lastw = a;
            for (int w = a; w <= n; w++)
                if (comp[w] == c)
                    lastw = w;
            for (int w = a; w <= n; w++)
                if (comp[w] == c && rows.size() < 64)
                begin
                    row = '{kind: KIND_MEMBER, value: w[NODE_W-1:0],
                            cend: (w == lastw), ovf: 1'b0, last: 1'b0};
                    rows = {rows, row};
                end
        end
        rows[rows.size() - 1].last = 1'b1;
        expected_results = {expected_results, rows};
        edge_src_q.delete();
        edge_dst_q.delete();
        edges_dropped = 0;
    endtask

    task automatic send_item(input int from_n, input int to_n, input bit with_edge,
                             input bit last_item);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, to_n[NODE_W-1:0], from_n[NODE_W-1:0]};
        s_tuser  <= with_edge;
        s_tlast  <= last_item;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        if (with_edge)
        begin
            if (edge_src_q.size() < EDGES)
            begin
                edge_src_q = {edge_src_q, from_n[NODE_W-1:0]};
                edge_dst_q = {edge_dst_q, to_n[NODE_W-1:0]};
            end
            else
                edges_dropped = 1;
        end
        if (last_item)
        begin
            graphs_sent++;
            predict_components();
        end
    endtask

    task automatic wait_drained();
        // Withdraw the last transaction before the block turns ready again.
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(input int count);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_NODE_COUNT;
        pwdata  <= count;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        node_count_cfg = count & 63;
    endtask

    // A random graph whose edges mostly stay among a few low nodes, so cycles form.
    task automatic send_random_graph(input int items);
        int span, f, t;
        bit with_edge;
        span = (node_count_cfg < 2) ? 2 : node_count_cfg;
        if ($urandom_range(0, 2) != 0 && span > 10)
            span = $urandom_range(3, 10);
        for (int i = 0; i < items; i++)
        begin
            with_edge = ($urandom_range(0, 9) != 0);
            if ($urandom_range(0, 11) == 0)
            begin
                f = $urandom_range(0, 63);
                t = $urandom_range(0, 63);
            end
            else
            begin
                f = $urandom_range(1, span);
                t = $urandom_range(1, span);
            end
            send_item(f, t, with_edge, i == items - 1);
        end
    endtask

    task automatic test_directed_graphs();
        quiet = 1;
        write_node_count(63);
        send_item(63, 1, 1, 0);
        send_item(1, 63, 1, 0);
        send_item(5, 5, 1, 0);
        send_item(63, 63, 0, 0);
        send_item(0, 3, 1, 0);
        send_item(3, 0, 1, 0);
        send_item(2, 62, 1, 1);
        wait_drained();
        write_node_count(1);
        send_item(1, 1, 1, 0);
        send_item(2, 1, 1, 0);
        send_item(1, 2, 1, 1);
        wait_drained();
        // With no nodes in use the header alone closes the run.
        write_node_count(0);
        send_item(0, 0, 0, 1);
        wait_drained();
        quiet = 0;
        write_node_count(7);
        send_item(1, 2, 1, 0);
        send_item(2, 3, 1, 0);
        send_item(3, 1, 1, 0);
        send_item(4, 5, 1, 0);
        send_item(5, 4, 1, 0);
        send_item(3, 4, 1, 0);
        send_item(7, 8, 1, 0);
        send_item(42, 21, 1, 0);
        send_item(6, 6, 0, 1);
        wait_drained();
    endtask

    task automatic test_random_graphs();
        int settings[5] = '{63, 1, 2, 17, 40};
        for (int s = 0; s < 5; s++)
        begin
            write_node_count(settings[s]);
            for (int g = 0; g < 4; g++)
                send_random_graph($urandom_range(2, 14));
            wait_drained();
        end
        write_node_count($urandom_range(1, 63));
        for (int g = 0; g < 4; g++)
            send_random_graph($urandom_range(1, 12));
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        write_node_count(63);
        hold_seq++;
        for (int g = 0; g < 4; g++)
            send_random_graph($urandom_range(4, 10));
        wait_drained();
    endtask

    // Result sink: random stalls, plus a long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_seen  <= 0;
            hold_left  <= 0;
            stall_left <= 0;
        end
        else if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 99) < 25)
        begin
            stall_left <= pick_gap();
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: kind %0b value %0d end %0b ovf %0b last %0b",
                             m_tuser, m_tdata[5:0], m_tdata[6], m_tdata[7], m_tlast);
            end
            else
            begin
                result_t want;
                want = expected_results.pop_front();
                if (m_tuser !== want.kind || m_tdata[5:0] !== want.value ||
                    m_tdata[6] !== want.cend || m_tdata[7] !== want.ovf ||
                    m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("Result %0d: expected kind %0b value %0d end %0b ",
                               results_seen, want.kind, want.value, want.cend);
                        $write("ovf %0b last %0b, ", want.ovf, want.last);
                        $display("got kind %0b value %0d end %0b ovf %0b last %0b",
                                 m_tuser, m_tdata[5:0], m_tdata[6], m_tdata[7], m_tlast);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        s_tuser  = 1'b0;
        mismatches = 0; results_seen = 0; graphs_sent = 0; items_sent = 0;
        cycle_count = 0; quiet = 0; hold_seq = 0;
        edges_dropped = 0;
        node_count_cfg = NODE_COUNT_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_graphs();
        test_random_graphs();
        test_output_backpressure();
        $display("Covered %0d graphs from %0d edge transactions, %0d result transactions,",
                 graphs_sent, items_sent, results_seen);
        $display("including node counts 0, 1 and 63, stray endpoints and a long output stall.");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                     expected_results.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/scc_pkg.sv
hdl/scc_ram.sv
hdl/scc_cfg.sv
hdl/scc_core.sv
hdl/strongly_connected_components.sv
bench/strongly_connected_components_tb.sv
